FILE: src/pte_pkg.sv
// ----------------------------------------------------------------------------
// pte_pkg
// Shared widths, constants, types and the arctangent table for the pose to
// Euler angle and velocity core.
// ----------------------------------------------------------------------------
package pte_pkg;

   localparam int StampW   = 48;
   localparam int PosW     = 32;
   localparam int QuatW    = 16;
   localparam int AngW     = 16;
   localparam int PitchW   = 15;
   localparam int VelW     = 32;
   localparam int MinDtW   = 20;
   localparam int ReqDataW = 208;
   localparam int RspDataW = 192;

   localparam int QuatFracBits = 14;
   localparam int CordicSteps  = 16;
   localparam int T30Shift     = 30 - 2 * QuatFracBits;

   localparam int ScW  = 36;
   localparam int CorW = 44;
   localparam int ZW   = 34;
   localparam int NumW = 53;

   localparam logic [MinDtW-1:0] MinDtReset = 20'd8000;
   localparam logic [MinDtW-1:0] UsPerS     = 20'd1000000;
   localparam logic signed [ZW-1:0] HalfPiQ30 = 34'sd1686629713;
   localparam logic signed [17:0] PiQ13     = 18'sd25736;
   localparam logic signed [17:0] HalfPiQ13 = 18'sd12868;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP1,
      ST_PREP2,
      ST_PREP3,
      ST_START,
      ST_ROLL,
      ST_YAW,
      ST_PITCH,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      SEL_ROLL,
      SEL_YAW,
      SEL_PITCH
   } angle_sel_type;

   typedef struct packed {
      logic          capture;
      logic          prep1;
      logic          prep2;
      logic          prep3;
      logic          start_div;
      logic          start_sqrt;
      logic          cordic_start;
      angle_sel_type cordic_sel;
      logic          store_roll;
      logic          store_yaw;
      logic          store_pitch;
      logic          out_load;
   } cmd_type;

   typedef struct packed {
      logic cordic_busy;
      logic sqrt_busy;
      logic div_busy;
   } stat_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:    v = 32'h3243F6A8;
         5'd1:    v = 32'h1DAC6705;
         5'd2:    v = 32'h0FADBAFC;
         5'd3:    v = 32'h07F56EA6;
         5'd4:    v = 32'h03FEAB76;
         5'd5:    v = 32'h01FFD55B;
         5'd6:    v = 32'h00FFFAAA;
         5'd7:    v = 32'h007FFF55;
         5'd8:    v = 32'h003FFFEA;
         5'd9:    v = 32'h001FFFFD;
         5'd10:   v = 32'h000FFFFF;
         5'd11:   v = 32'h0007FFFF;
         5'd12:   v = 32'h0003FFFF;
         5'd13:   v = 32'h0001FFFF;
         5'd14:   v = 32'h0000FFFF;
         5'd15:   v = 32'h00007FFF;
         5'd16:   v = 32'h00003FFF;
         5'd17:   v = 32'h00001FFF;
         5'd18:   v = 32'h00000FFF;
         5'd19:   v = 32'h000007FF;
         5'd20:   v = 32'h000003FF;
         5'd21:   v = 32'h000001FF;
         5'd22:   v = 32'h000000FF;
         5'd23:   v = 32'h0000007F;
         5'd24:   v = 32'h0000003F;
         5'd25:   v = 32'h0000001F;
         5'd26:   v = 32'h0000000F;
         5'd27:   v = 32'h00000008;
         5'd28:   v = 32'h00000004;
         5'd29:   v = 32'h00000002;
         5'd30:   v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

FILE: src/pose_to_euler_and_velocity_core.sv
// Schedule: three CORDIC runs on one shared unit (normalize steps plus
//   CORDIC_STEPS rotation steps each) run in sequence; the dividers and
//   square root overlap them.
// Items: one item at a time, accepted only when idle; a waiting result does
//   not block the next accept, only the next result load.
// Reset: synchronous, clears origin, previous pose and min_dt_us to 8000.
// ----------------------------------------------------------------------------
// pose_to_euler_and_velocity_core
// Pose to roll, pitch, yaw and per-axis velocity, one result item per item.
// ----------------------------------------------------------------------------
module pose_to_euler_and_velocity_core #(
   parameter int CORDIC_STEPS = pte_pkg::CordicSteps
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // stamp_us[47:0], pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z
   input  logic [pte_pkg::ReqDataW-1:0]  req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // rel_time_us[47:0], roll, pitch(15), yaw, vel_x, vel_y, vel_z, zero pad
   output logic [pte_pkg::RspDataW-1:0]  rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pte_pkg::MinDtW-1:0]    csr_data
);

   pte_pkg::cmd_type  cmd;
   pte_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   pte_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pte_dp #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_tdata),
      .csr_write (csr_valid & csr_ready),
      .csr_data  (csr_data),
      .rsp_data  (rsp_tdata)
   );

endmodule

FILE: src/pte_dp.sv
// ----------------------------------------------------------------------------
// pte_dp
// Datapath: origin and time step, quaternion products, iterative square
// root, shared CORDIC vectoring unit, three restoring dividers, output data.
// ----------------------------------------------------------------------------
module pte_dp #(
   parameter int CORDIC_STEPS = pte_pkg::CordicSteps
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pte_pkg::cmd_type               cmd,
   output pte_pkg::stat_type              stat,
   input  logic [pte_pkg::ReqDataW-1:0]   req_data,
   input  logic                           csr_write,
   input  logic [pte_pkg::MinDtW-1:0]     csr_data,
   output logic [pte_pkg::RspDataW-1:0]   rsp_data
);

   localparam int ScW  = pte_pkg::ScW;
   localparam int CorW = pte_pkg::CorW;
   localparam int ZW   = pte_pkg::ZW;
   localparam int NumW = pte_pkg::NumW;
   localparam int CntW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam logic signed [ScW-1:0] QOne = ScW'(64'd1 << (2 * pte_pkg::QuatFracBits));
   localparam logic [CorW-1:0] M22 = CorW'(64'd1 << 22);
   localparam logic [CorW-1:0] M30 = CorW'(64'd1 << 30);
   localparam logic [CorW-1:0] M34 = CorW'(64'd1 << 34);
   localparam logic [CorW-1:0] M36 = CorW'(64'd1 << 36);
   localparam logic [CorW-1:0] M38 = CorW'(64'd1 << 38);

   function automatic logic signed [ScW-1:0] sx(input logic signed [31:0] v);
      return {{(ScW-32){v[31]}}, v};
   endfunction

   function automatic logic [17:0] to_q13(input logic signed [ZW-1:0] z,
                                          input logic signed [17:0] lim);
      logic signed [ZW:0] zr;
      logic signed [17:0] a;
      zr = $signed({z[ZW-1], z} + (ZW+1)'(65536));
      a  = 18'(zr >>> 17);
      if (a > lim) begin
         a = lim;
      end else if (a < -lim) begin
         a = -lim;
      end
      return a;
   endfunction

   function automatic logic [31:0] vel_sat(input logic [NumW-1:0] q, input logic neg);
      logic [NumW-1:0] nq;
      nq = NumW'(0) - q;
      if (!neg) begin
         return (q > NumW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : q[31:0];
      end
      return (q > NumW'(32'h80000000)) ? 32'h80000000 : nq[31:0];
   endfunction

   // control state
   logic [19:0]        min_dt_ff;
   logic               origin_seen_ff;
   logic [47:0]        origin_ff;
   logic [47:0]        prev_time_ff;
   logic signed [31:0] prev_pos_ff [3];
   logic               cor_busy_ff, cor_norm_ff, sq_busy_ff, div_busy_ff;

   // payload
   logic [47:0]        rel_ff;
   logic signed [31:0] pos_ff [3];
   logic signed [15:0] qw_ff, qx_ff, qy_ff, qz_ff;
   logic [47:0]        dt_ff;
   logic signed [32:0] diff_ff [3];
   logic signed [31:0] p_xz_ff, p_wy_ff, p_wx_ff, p_yz_ff, p_xx_ff;
   logic signed [31:0] p_yy_ff, p_xy_ff, p_wz_ff, p_zz_ff;
   logic signed [ScW-1:0] s2_ff, c2_ff, s3_ff, c3_ff, t30_ff;
   logic [32:0]        dmag_ff [3];
   logic               dneg_ff [3];
   logic [61:0]        sq_ff;
   logic [NumW-1:0]    num_ff [3];
   logic [48:0]        rem_ff [3];
   logic [5:0]         div_cnt_ff;
   logic [60:0]        sq_n_ff;
   logic [61:0]        sq_res_ff;
   logic [4:0]         sq_k_ff;
   logic signed [CorW-1:0] x_ff, y_ff;
   logic signed [ZW-1:0]   z_ff;
   logic [CntW-1:0]    cor_i_ff;
   logic [15:0]        roll_ff, yaw_ff;
   logic [14:0]        pitch_ff;
   logic [pte_pkg::RspDataW-1:0] rsp_data_ff;

   // combinational
   logic [47:0]        stamp_w, origin_w, rel_in;
   logic signed [48:0] dt_raw;
   logic [19:0]        min_dt_eff;
   logic [47:0]        dt_in;
   logic signed [ScW-1:0] s1_w, s1c_w, cy_w, cx_w, t30m_w;
   logic [30:0]        t30_mag;
   logic [61:0]        sq_bit, sq_trial;
   logic [CorW-1:0]    ax_w, ay_w, m_w;
   logic [4:0]         nsh_w;
   logic signed [CorW-1:0] xs_w, ys_w;
   logic signed [ZW-1:0]   atan_w;
   logic [48:0]        rem_sh [3];

   assign stamp_w  = req_data[47:0];
   assign origin_w = origin_seen_ff ? origin_ff : stamp_w;
   assign rel_in   = stamp_w - origin_w;

   assign dt_raw     = $signed({1'b0, rel_ff}) - $signed({1'b0, prev_time_ff});
   assign min_dt_eff = (min_dt_ff == '0) ? 20'd1 : min_dt_ff;
   assign dt_in      = (dt_raw < $signed({29'b0, min_dt_eff})) ? {28'b0, min_dt_eff}
                                                               : dt_raw[47:0];

   assign s1_w  = (sx(p_wy_ff) - sx(p_xz_ff)) <<< 1;
   assign s1c_w = (s1_w > QOne) ? QOne : ((s1_w < -QOne) ? -QOne : s1_w);

   assign t30m_w  = t30_ff[ScW-1] ? -t30_ff : t30_ff;
   assign t30_mag = t30m_w[30:0];

   assign sq_bit   = 62'(1) << {sq_k_ff, 1'b0};
   assign sq_trial = sq_res_ff + sq_bit;

   always_comb begin
      case (cmd.cordic_sel)
         pte_pkg::SEL_YAW: begin
            cy_w = s3_ff;
            cx_w = c3_ff;
         end
         pte_pkg::SEL_PITCH: begin
            cy_w = t30_ff;
            cx_w = {{(ScW-31){1'b0}}, sq_res_ff[30:0]};
         end
         default: begin
            cy_w = s2_ff;
            cx_w = c2_ff;
         end
      endcase
   end

   assign ax_w = x_ff[CorW-1] ? CorW'(-x_ff) : CorW'(x_ff);
   assign ay_w = y_ff[CorW-1] ? CorW'(-y_ff) : CorW'(y_ff);
   assign m_w  = (ax_w > ay_w) ? ax_w : ay_w;

   always_comb begin
      if (m_w < M22) begin
         nsh_w = 5'd16;
      end else if (m_w < M30) begin
         nsh_w = 5'd8;
      end else if (m_w < M34) begin
         nsh_w = 5'd4;
      end else if (m_w < M36) begin
         nsh_w = 5'd2;
      end else begin
         nsh_w = 5'd1;
      end
   end

   assign xs_w   = x_ff >>> cor_i_ff;
   assign ys_w   = y_ff >>> cor_i_ff;
   assign atan_w = ZW'(pte_pkg::atan_entry(5'(cor_i_ff)));

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rem_sh[k] = {rem_ff[k][47:0], num_ff[k][NumW-1]};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_dt_ff      <= pte_pkg::MinDtReset;
         origin_seen_ff <= 1'b0;
         origin_ff      <= '0;
         prev_time_ff   <= '0;
         for (int k = 0; k < 3; k++) begin
            prev_pos_ff[k] <= '0;
         end
         cor_busy_ff <= 1'b0;
         cor_norm_ff <= 1'b0;
         sq_busy_ff  <= 1'b0;
         div_busy_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            min_dt_ff <= csr_data;
         end
         if (cmd.capture) begin
            origin_seen_ff <= 1'b1;
            origin_ff      <= origin_w;
         end
         if (cmd.prep1) begin
            prev_time_ff <= rel_ff;
            for (int k = 0; k < 3; k++) begin
               prev_pos_ff[k] <= pos_ff[k];
            end
         end
         if (cmd.start_div) begin
            div_busy_ff <= 1'b1;
         end else if (div_busy_ff && div_cnt_ff == '0) begin
            div_busy_ff <= 1'b0;
         end
         if (cmd.start_sqrt) begin
            sq_busy_ff <= 1'b1;
         end else if (sq_busy_ff && sq_k_ff == '0) begin
            sq_busy_ff <= 1'b0;
         end
         if (cmd.cordic_start) begin
            cor_busy_ff <= (cy_w != '0) || (cx_w != '0);
            cor_norm_ff <= 1'b1;
         end else if (cor_busy_ff && cor_norm_ff) begin
            if (m_w >= M38) begin
               cor_norm_ff <= 1'b0;
            end
         end else if (cor_busy_ff && cor_i_ff == CntW'(CORDIC_STEPS - 1)) begin
            cor_busy_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rel_ff    <= rel_in;
         pos_ff[0] <= req_data[79:48];
         pos_ff[1] <= req_data[111:80];
         pos_ff[2] <= req_data[143:112];
         qw_ff     <= req_data[159:144];
         qx_ff     <= req_data[175:160];
         qy_ff     <= req_data[191:176];
         qz_ff     <= req_data[207:192];
      end
      if (cmd.prep1) begin
         dt_ff <= dt_in;
         for (int k = 0; k < 3; k++) begin
            diff_ff[k] <= {pos_ff[k][31], pos_ff[k]} - {prev_pos_ff[k][31], prev_pos_ff[k]};
         end
         p_xz_ff <= 32'(qx_ff) * 32'(qz_ff);
         p_wy_ff <= 32'(qw_ff) * 32'(qy_ff);
         p_wx_ff <= 32'(qw_ff) * 32'(qx_ff);
         p_yz_ff <= 32'(qy_ff) * 32'(qz_ff);
         p_xx_ff <= 32'(qx_ff) * 32'(qx_ff);
         p_yy_ff <= 32'(qy_ff) * 32'(qy_ff);
         p_xy_ff <= 32'(qx_ff) * 32'(qy_ff);
         p_wz_ff <= 32'(qw_ff) * 32'(qz_ff);
         p_zz_ff <= 32'(qz_ff) * 32'(qz_ff);
      end
      if (cmd.prep2) begin
         s2_ff  <= (sx(p_wx_ff) + sx(p_yz_ff)) <<< 1;
         c2_ff  <= QOne - ((sx(p_xx_ff) + sx(p_yy_ff)) <<< 1);
         s3_ff  <= (sx(p_xy_ff) + sx(p_wz_ff)) <<< 1;
         c3_ff  <= QOne - ((sx(p_yy_ff) + sx(p_zz_ff)) <<< 1);
         t30_ff <= s1c_w <<< pte_pkg::T30Shift;
         for (int k = 0; k < 3; k++) begin
            dneg_ff[k] <= diff_ff[k][32];
            dmag_ff[k] <= diff_ff[k][32] ? 33'(-diff_ff[k]) : 33'(diff_ff[k]);
         end
      end
      if (cmd.prep3) begin
         sq_ff <= 62'(t30_mag) * 62'(t30_mag);
         for (int k = 0; k < 3; k++) begin
            num_ff[k] <= NumW'(dmag_ff[k]) * NumW'(pte_pkg::UsPerS);
         end
      end

      // restoring division, one quotient bit per lane per cycle
      if (cmd.start_div) begin
         div_cnt_ff <= 6'(NumW - 1);
         for (int k = 0; k < 3; k++) begin
            rem_ff[k] <= '0;
         end
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff - 6'd1;
         for (int k = 0; k < 3; k++) begin
            if (rem_sh[k] >= {1'b0, dt_ff}) begin
               rem_ff[k] <= rem_sh[k] - {1'b0, dt_ff};
               num_ff[k] <= {num_ff[k][NumW-2:0], 1'b1};
            end else begin
               rem_ff[k] <= rem_sh[k];
               num_ff[k] <= {num_ff[k][NumW-2:0], 1'b0};
            end
         end
      end

      // square root, one result bit per cycle
      if (cmd.start_sqrt) begin
         sq_n_ff   <= (61'(1) << 60) - 61'(sq_ff);
         sq_res_ff <= '0;
         sq_k_ff   <= 5'd30;
      end else if (sq_busy_ff) begin
         sq_k_ff <= sq_k_ff - 5'd1;
         if ({1'b0, sq_n_ff} >= sq_trial) begin
            sq_n_ff   <= 61'({1'b0, sq_n_ff} - sq_trial);
            sq_res_ff <= (sq_res_ff >> 1) + sq_bit;
         end else begin
            sq_res_ff <= sq_res_ff >> 1;
         end
      end

      // CORDIC vectoring: normalize, fold into right half plane, rotate
      if (cmd.cordic_start) begin
         x_ff     <= {{(CorW-ScW){cx_w[ScW-1]}}, cx_w};
         y_ff     <= {{(CorW-ScW){cy_w[ScW-1]}}, cy_w};
         z_ff     <= '0;
         cor_i_ff <= '0;
      end else if (cor_busy_ff && cor_norm_ff) begin
         if (m_w >= M38) begin
            if (x_ff[CorW-1]) begin
               if (!y_ff[CorW-1]) begin
                  x_ff <= y_ff;
                  y_ff <= -x_ff;
                  z_ff <= pte_pkg::HalfPiQ30;
               end else begin
                  x_ff <= -y_ff;
                  y_ff <= x_ff;
                  z_ff <= -pte_pkg::HalfPiQ30;
               end
            end
         end else begin
            x_ff <= x_ff <<< nsh_w;
            y_ff <= y_ff <<< nsh_w;
         end
      end else if (cor_busy_ff) begin
         cor_i_ff <= cor_i_ff + CntW'(1);
         if (!y_ff[CorW-1]) begin
            x_ff <= x_ff + ys_w;
            y_ff <= y_ff - xs_w;
            z_ff <= z_ff + atan_w;
         end else begin
            x_ff <= x_ff - ys_w;
            y_ff <= y_ff + xs_w;
            z_ff <= z_ff - atan_w;
         end
      end

      if (cmd.store_roll) begin
         roll_ff <= 16'(to_q13(z_ff, pte_pkg::PiQ13));
      end
      if (cmd.store_yaw) begin
         yaw_ff <= 16'(to_q13(z_ff, pte_pkg::PiQ13));
      end
      if (cmd.store_pitch) begin
         pitch_ff <= 15'(to_q13(z_ff, pte_pkg::HalfPiQ13));
      end
      if (cmd.out_load) begin
         rsp_data_ff <= {1'b0,
                         vel_sat(num_ff[2], dneg_ff[2]),
                         vel_sat(num_ff[1], dneg_ff[1]),
                         vel_sat(num_ff[0], dneg_ff[0]),
                         yaw_ff, pitch_ff, roll_ff, rel_ff};
      end
   end

   assign rsp_data         = rsp_data_ff;
   assign stat.cordic_busy = cor_busy_ff;
   assign stat.sqrt_busy   = sq_busy_ff;
   assign stat.div_busy    = div_busy_ff;

endmodule

FILE: src/pte_ctrl.sv
// ----------------------------------------------------------------------------
// pte_ctrl
// Sequencer: accepts an item, steps the datapath through setup, runs the
// CORDIC unit for roll, yaw and pitch, and loads the result register.
// ----------------------------------------------------------------------------
module pte_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  pte_pkg::stat_type stat,
   output pte_pkg::cmd_type  cmd
);

   pte_pkg::state_type state_ff, state_in;
   logic               rsp_tvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pte_pkg::ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.out_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.cordic_sel = pte_pkg::SEL_ROLL;
      case (state_ff)
         pte_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = pte_pkg::ST_PREP1;
            end
         end
         pte_pkg::ST_PREP1: begin
            cmd.prep1 = 1'b1;
            state_in  = pte_pkg::ST_PREP2;
         end
         pte_pkg::ST_PREP2: begin
            cmd.prep2 = 1'b1;
            state_in  = pte_pkg::ST_PREP3;
         end
         pte_pkg::ST_PREP3: begin
            cmd.prep3 = 1'b1;
            state_in  = pte_pkg::ST_START;
         end
         pte_pkg::ST_START: begin
            cmd.start_div    = 1'b1;
            cmd.start_sqrt   = 1'b1;
            cmd.cordic_start = 1'b1;
            state_in         = pte_pkg::ST_ROLL;
         end
         pte_pkg::ST_ROLL: begin
            if (!stat.cordic_busy) begin
               cmd.store_roll   = 1'b1;
               cmd.cordic_start = 1'b1;
               cmd.cordic_sel   = pte_pkg::SEL_YAW;
               state_in         = pte_pkg::ST_YAW;
            end
         end
         pte_pkg::ST_YAW: begin
            if (!stat.cordic_busy && !stat.sqrt_busy) begin
               cmd.store_yaw    = 1'b1;
               cmd.cordic_start = 1'b1;
               cmd.cordic_sel   = pte_pkg::SEL_PITCH;
               state_in         = pte_pkg::ST_PITCH;
            end
         end
         pte_pkg::ST_PITCH: begin
            if (!stat.cordic_busy) begin
               cmd.store_pitch = 1'b1;
               state_in        = pte_pkg::ST_DONE;
            end
         end
         pte_pkg::ST_DONE: begin
            if (!stat.div_busy && (!rsp_tvalid_ff || rsp_tready)) begin
               cmd.out_load = 1'b1;
               state_in     = pte_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pte_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == pte_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   a_idle_units_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pte_pkg::ST_IDLE) |-> !stat.cordic_busy && !stat.sqrt_busy
                                         && !stat.div_busy)
      else $error("unit busy while idle");

   a_load_after_units: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !stat.div_busy && !stat.cordic_busy)
      else $error("result loaded before units finished");

   a_pitch_needs_sqrt: assert property (@(posedge clock) disable iff (reset)
      (cmd.cordic_start && cmd.cordic_sel == pte_pkg::SEL_PITCH) |-> !stat.sqrt_busy)
      else $error("pitch started before square root finished");

   a_load_shows_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_tvalid)
      else $error("loaded result not presented");

endmodule
